[sv/assert_macros.svh]
// Assertion macros shared by the RTL files of the bit-plane packer.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion that is switched off while the synchronous reset is held.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked assertion that is checked on every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

[sv/pbp_pkg.sv]
// Types, constants and the colour classifier of the bit-plane packer.
// No dependencies.
package pbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int CMP_W      = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int PIX_W      = 24;

  localparam logic [PIX_W-1:0] MAGENTA = 24'hFF00FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOUR_MODE  = 2'd0,
    REG_USE_TRANSP   = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2
  } cfg_reg_t;

  // Red, green or blue code when that channel is set and the other two are below 8.
  function automatic logic [1:0] classify(input logic [PIX_W-1:0] c);
    logic [1:0] code;
    if ((c & 24'hFF0000) != '0 && (c & 24'h00F8F8) == '0) begin
      code = 2'd1;
    end else if ((c & 24'h00FF00) != '0 && (c & 24'hF800F8) == '0) begin
      code = 2'd2;
    end else if ((c & 24'h0000FF) != '0 && (c & 24'hF8F800) == '0) begin
      code = 2'd3;
    end else begin
      code = 2'd0;
    end
    return code;
  endfunction

endpackage

[sv/pixel_to_bitplane_packer.sv]
// Top level of the bit-plane packer: pixel classification, byte assembly and output.
// Depends on pbp_pkg and assert_macros.svh.

// Accepts one 24-bit pixel per beat in row order and returns the packed display
// bytes, one byte per output beat. Each pixel yields zero, one, two or four bytes;
// the bytes of a pixel are loaded as one group into an output shift register, and
// a new pixel is taken in the same cycle as the last byte of the previous group
// leaves, so the one-byte-wide output register and out_ready pace the input.
// Configuration writes take effect from the next pixel and do not clear the
// partial byte already gathered.
`include "assert_macros.svh"

module pixel_to_bitplane_packer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pbp_pkg::PIX_W-1:0]      in_pixel_rgb,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_row_end,
  output logic                           out_run_last
);
  import pbp_pkg::*;

  logic             colour_mode_r;
  logic             use_transp_r;
  logic [WID_W-1:0] image_width_r;

  logic [COL_W-1:0] column_r, column_nxt;
  logic [15:0]      data_accum_r, data_accum_nxt;
  logic [15:0]      mask_accum_r, mask_accum_nxt;
  logic             phase_r, phase_nxt;

  logic [31:0]      grp_data_r;
  logic [2:0]       grp_left_r;
  logic             grp_valid_r;
  logic             grp_row_end_r;

  logic [CMP_W-1:0] width_ext, eff_width;
  logic             row_end, wide, byte_done;
  logic [2:0]       pos;
  logic [3:0]       shift;
  logic [1:0]       val;
  logic [15:0]      data_or, mask_or;
  logic [2:0]       n_bytes;
  logic [31:0]      grp_load;
  logic             in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = !grp_valid_r || (out_ready && grp_left_r == 3'd1);

  assign out_valid    = grp_valid_r;
  assign out_byte     = grp_data_r[7:0];
  assign out_run_last = grp_left_r == 3'd1;
  assign out_row_end  = out_run_last && grp_row_end_r;

  // Effective width: zero counts as one, anything above the maximum saturates.
  assign width_ext = CMP_W'(image_width_r);
  always_comb begin
    if (image_width_r == '0) begin
      eff_width = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      eff_width = CMP_W'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
  end

  assign row_end = (CMP_W'(column_r) + CMP_W'(1)) >= eff_width;
  assign wide    = use_transp_r && (eff_width >= CMP_W'(16));
  assign pos     = colour_mode_r ? {1'b0, column_r[1:0]} : column_r[2:0];
  assign byte_done = (colour_mode_r ? (column_r[1:0] == 2'd3) : (column_r[2:0] == 3'd7))
                     || row_end;
  assign shift   = (colour_mode_r ? {pos[2:0], 1'b0} : {1'b0, pos})
                   + ((wide && phase_r) ? 4'd8 : 4'd0);
  assign val     = colour_mode_r ? classify(in_pixel_rgb)
                                 : {1'b0, (in_pixel_rgb != '0)};

  always_comb begin
    data_or = data_accum_r;
    mask_or = mask_accum_r;
    if (!use_transp_r) begin
      data_or = data_accum_r | ({14'd0, val} << shift);
    end else if (in_pixel_rgb != MAGENTA) begin
      data_or = data_accum_r | ({14'd0, val} << shift);
      mask_or = mask_accum_r | ({14'd0, colour_mode_r, 1'b1} << shift);
    end
  end

  // Byte group of this pixel, first byte in the low lane.
  always_comb begin
    n_bytes   = 3'd0;
    grp_load  = {16'd0, data_or};
    phase_nxt = phase_r;
    if (byte_done) begin
      if (!use_transp_r) begin
        n_bytes  = 3'd1;
        grp_load = {24'd0, data_or[7:0]};
      end else if (!wide || (!phase_r && row_end)) begin
        // Narrow rows, and a lone trailing byte of a wide row: mask then data.
        n_bytes  = 3'd2;
        grp_load = {16'd0, data_or[7:0], mask_or[7:0]};
      end else if (!phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        n_bytes  = 3'd4;
        grp_load = {data_or, mask_or};
      end
    end
    if (n_bytes != 3'd0) begin
      data_accum_nxt = '0;
      mask_accum_nxt = '0;
      phase_nxt      = 1'b0;
    end else begin
      data_accum_nxt = data_or;
      mask_accum_nxt = mask_or;
    end
    column_nxt = row_end ? '0 : column_r + COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_mode_r <= 1'b0;
      use_transp_r  <= 1'b0;
      image_width_r <= WID_W'(1);
      column_r      <= '0;
      data_accum_r  <= '0;
      mask_accum_r  <= '0;
      phase_r       <= 1'b0;
      grp_valid_r   <= 1'b0;
      grp_left_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_COLOUR_MODE: colour_mode_r <= cfg_wdata[0];
          REG_USE_TRANSP:  use_transp_r  <= cfg_wdata[0];
          REG_IMAGE_WIDTH: image_width_r <= cfg_wdata[WID_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        column_r     <= column_nxt;
        data_accum_r <= data_accum_nxt;
        mask_accum_r <= mask_accum_nxt;
        phase_r      <= phase_nxt;
      end
      if (in_fire && n_bytes != 3'd0) begin
        grp_valid_r <= 1'b1;
        grp_left_r  <= n_bytes;
      end else if (out_fire) begin
        grp_valid_r <= grp_left_r != 3'd1;
        grp_left_r  <= grp_left_r - 3'd1;
      end
    end
  end

  // Output shift register; the byte on the port is always the low lane.
  always_ff @(posedge clk) begin
    if (in_fire && n_bytes != 3'd0) begin
      grp_data_r    <= grp_load;
      grp_row_end_r <= row_end;
    end else if (out_fire) begin
      grp_data_r    <= {8'd0, grp_data_r[31:8]};
    end
  end

  `ASSERT_CLK_RST(a_group_count, clk, rst_n,
    grp_valid_r |-> (grp_left_r != 3'd0 && grp_left_r <= 3'd4))
  `ASSERT_CLK_RST(a_idle_ready, clk, rst_n, !out_valid |-> in_ready)
  `ASSERT_CLK_RST(a_row_wrap, clk, rst_n, (in_fire && row_end) |=> column_r == '0)
  `ASSERT_CLK_RST(a_accum_clear, clk, rst_n,
    (in_fire && n_bytes != 3'd0) |=> (data_accum_r == '0 && mask_accum_r == '0 && !phase_r))
  `ASSERT_CLK(a_row_end_last, clk, (out_valid && out_row_end) |-> out_run_last)

endmodule
